>>> design/aalr_pkg.sv
// Shared types and constants of the area-average line resampler.
package aalr_pkg;

  localparam int LEN_REG_W  = 13;
  localparam int INV_W      = 25;
  localparam int INDEX_W    = 12;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int FRAC_W     = 24;
  localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

  localparam logic [LEN_REG_W-1:0] LEN_RESET = LEN_REG_W'(1);
  localparam logic [INV_W-1:0]     INV_RESET = INV_W'(2 ** FRAC_W);

  typedef enum logic [1:0] {
    REG_IN_LENGTH     = 2'd0,
    REG_OUT_LENGTH    = 2'd1,
    REG_INV_IN_LENGTH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LEN_REG_W-1:0] in_length;
    logic [LEN_REG_W-1:0] out_length;
    logic [INV_W-1:0]     inv_in_length;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_SCALE,
    ST_EMIT
  } seq_state_e;

endpackage

>>> design/aalr_in_if.sv
// Input stream channel: one sample word per handshake.
interface aalr_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   line_start;

  modport source (output valid, output sample, output line_start, input ready);
  modport sink   (input valid, input sample, input line_start, output ready);
endinterface

>>> design/aalr_out_if.sv
// Output stream channel: one resampled word per handshake.
interface aalr_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [SAMPLE_BITS-1:0]       value;
  logic [aalr_pkg::INDEX_W-1:0] out_index;
  logic                         last_of_run;
  logic                         last_of_line;

  modport source (output valid, output value, output out_index, output last_of_run,
                  output last_of_line, input ready);
  modport sink   (input valid, input value, input out_index, input last_of_run,
                  input last_of_line, output ready);
endinterface

>>> design/area_average_line_resampler.sv
// Top level of the area-average line resampler: sequencer, datapath and output register.
//
//   channel  dir  handshake        word
//   in_i     in   valid/ready      sample, line_start
//   out_o    out  valid/ready      value, out_index, last_of_run, last_of_line
//   apb      in   psel/penable     in_length, out_length, inv_in_length (0x0, 0x4, 0x8)
//
// An item that closes no bin is accepted, then its tail is accumulated.
// Each emitted bin runs a weight MAC, NCHUNK reciprocal chunks of SAMPLE_BITS bits
// and the emit step; a bin inside one sample runs its check and the emit step.
// Bins past MAX_UPSAMPLE in one sample are consumed without a result. All of it
// runs on one shared multiplier. A full output register stalls the emit step only.
// Reset is asynchronous; no clearing pass is needed.
module area_average_line_resampler #(
  parameter int MAX_LENGTH   = 4096,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_UPSAMPLE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  aalr_in_if.sink                         in_i,
  aalr_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aalr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [aalr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [aalr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int LB     = $clog2(MAX_LENGTH);
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int CNT_W  = LEN_W;
  localparam int POS_W  = 2 * LB + 2;
  localparam int ACC_W  = SAMPLE_BITS + LB;
  localparam int NCHUNK = (ACC_W + SAMPLE_BITS - 1) / SAMPLE_BITS;
  localparam int PAD_W  = NCHUNK * SAMPLE_BITS;
  localparam int P_W    = PAD_W + aalr_pkg::INV_W;
  localparam int RND_W  = P_W + 1;
  localparam int RES_W  = RND_W - aalr_pkg::FRAC_W;
  localparam int N_W    = $clog2(MAX_UPSAMPLE + 1);
  localparam int K_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  aalr_pkg::cfg_t cfg;

  aalr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective lengths: zero acts as one, oversize acts as MAX_LENGTH
  logic [LEN_W-1:0] il, ol;

  always_comb begin
    if (cfg.in_length == '0) begin
      il = LEN_W'(1);
    end else if (32'(cfg.in_length) > 32'(MAX_LENGTH)) begin
      il = LEN_W'(MAX_LENGTH);
    end else begin
      il = LEN_W'(cfg.in_length);
    end
    if (cfg.out_length == '0) begin
      ol = LEN_W'(1);
    end else if (32'(cfg.out_length) > 32'(MAX_LENGTH)) begin
      ol = LEN_W'(MAX_LENGTH);
    end else begin
      ol = LEN_W'(cfg.out_length);
    end
  end

  aalr_pkg::seq_state_e state_q, state_d;

  logic                   started_q, started_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [POS_W-1:0]       bin_end_q, bin_end_d;
  logic [POS_W-1:0]       cur_q, cur_d;
  logic [POS_W-1:0]       seg_end_q, seg_end_d;
  logic [POS_W-1:0]       thr_q, thr_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [N_W-1:0]         n_q, n_d;
  logic [P_W-1:0]         prod_q, prod_d;
  logic [K_W-1:0]         k_q, k_d;
  logic                   direct_q, direct_d;

  logic                         ov_q, ov_d;
  logic [SAMPLE_BITS-1:0]       oval_q, oval_d;
  logic [aalr_pkg::INDEX_W-1:0] oidx_q, oidx_d;
  logic                         orun_q, orun_d;
  logic                         oline_q, oline_d;

  // shared MAC operands
  logic [SAMPLE_BITS-1:0]         mac_a;
  logic [aalr_pkg::INV_W-1:0]     mac_b;
  logic [P_W-1:0]                 mac_base;
  logic                           mac_shift;
  logic [P_W-1:0]                 mac_sum;

  logic                   in_fire, restart, out_free, loop_cond, more;
  logic [POS_W-1:0]       pos_eff, pos_a, w_diff, be_next, cur_max;
  logic [CNT_W-1:0]       cnt_eff, cnt_inc;
  logic [PAD_W-1:0]       acc_pad;
  logic [RND_W-1:0]       rnd_sum;
  logic [RES_W-1:0]       rnd_res;
  logic [SAMPLE_BITS-1:0] scaled;

  assign in_i.ready = (state_q == aalr_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign restart    = in_i.line_start || !started_q;
  assign pos_eff    = restart ? '0 : pos_q;
  assign cnt_eff    = restart ? '0 : cnt_q;

  assign out_free   = !ov_q || out_o.ready;
  assign loop_cond  = (cnt_q < ol) && (bin_end_q <= seg_end_q);

  // overlap of the current segment with the bin (or with the tail of the sample)
  assign pos_a   = loop_cond ? bin_end_q : seg_end_q;
  assign w_diff  = (pos_a > cur_q) ? pos_a - cur_q : '0;
  assign cur_max = (bin_end_q > cur_q) ? bin_end_q : cur_q;
  assign be_next = bin_end_q + POS_W'(il);
  assign cnt_inc = cnt_q + 1'b1;
  assign more    = (cnt_inc < ol) && (be_next <= seg_end_q)
                   && ((32'(n_q) + 1) < MAX_UPSAMPLE);

  // reciprocal scaling, MSB chunk first
  assign acc_pad = PAD_W'(acc_q);
  assign rnd_sum = {1'b0, prod_q} + RND_W'(aalr_pkg::ROUND_HALF);
  assign rnd_res = rnd_sum[RND_W-1:aalr_pkg::FRAC_W];
  assign scaled  = (|rnd_res[RES_W-1:SAMPLE_BITS]) ? '1 : rnd_res[SAMPLE_BITS-1:0];

  always_comb begin
    if (state_q == aalr_pkg::ST_SCALE) begin
      mac_a     = acc_pad[k_q*SAMPLE_BITS +: SAMPLE_BITS];
      mac_b     = cfg.inv_in_length;
      mac_base  = prod_q;
      mac_shift = 1'b1;
    end else begin
      mac_a     = sample_q;
      mac_b     = aalr_pkg::INV_W'(w_diff[LEN_W-1:0]);
      mac_base  = P_W'(acc_q);
      mac_shift = 1'b0;
    end
  end

  aalr_mac #(
    .A_W (SAMPLE_BITS),
    .B_W (aalr_pkg::INV_W),
    .P_W (P_W)
  ) u_mac (
    .a_i     (mac_a),
    .b_i     (mac_b),
    .base_i  (mac_base),
    .shift_i (mac_shift),
    .sum_o   (mac_sum)
  );

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    sample_d  = sample_q;
    pos_d     = pos_q;
    bin_end_d = bin_end_q;
    cur_d     = cur_q;
    seg_end_d = seg_end_q;
    thr_d     = thr_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    prod_d    = prod_q;
    k_d       = k_q;
    direct_d  = direct_q;
    ov_d      = ov_q && !out_o.ready;
    oval_d    = oval_q;
    oidx_d    = oidx_q;
    orun_d    = orun_q;
    oline_d   = oline_q;

    case (state_q)
      aalr_pkg::ST_IDLE: begin
        if (in_fire) begin
          started_d = 1'b1;
          sample_d  = in_i.sample;
          pos_d     = pos_eff;
          bin_end_d = restart ? POS_W'(il) : bin_end_q;
          acc_d     = restart ? '0 : acc_q;
          cnt_d     = cnt_eff;
          cur_d     = pos_eff;
          seg_end_d = pos_eff + POS_W'(ol);
          thr_d     = pos_eff + POS_W'(il);
          n_d       = '0;
          // line already complete: the sample is dropped
          state_d   = (cnt_eff >= ol) ? aalr_pkg::ST_IDLE : aalr_pkg::ST_LOOP;
        end
      end

      aalr_pkg::ST_LOOP: begin
        if (!loop_cond) begin
          if (cnt_q < ol) begin
            acc_d = mac_sum[ACC_W-1:0];
          end
          pos_d   = seg_end_q;
          state_d = aalr_pkg::ST_IDLE;
        end else if (32'(n_q) == MAX_UPSAMPLE) begin
          // run full: bin is consumed without a result
          acc_d     = '0;
          cur_d     = cur_max;
          cnt_d     = cnt_inc;
          bin_end_d = be_next;
        end else if (bin_end_q >= thr_q) begin
          direct_d = 1'b1;
          state_d  = aalr_pkg::ST_EMIT;
        end else begin
          direct_d = 1'b0;
          acc_d    = mac_sum[ACC_W-1:0];
          prod_d   = '0;
          k_d      = K_W'(NCHUNK - 1);
          state_d  = aalr_pkg::ST_SCALE;
        end
      end

      aalr_pkg::ST_SCALE: begin
        prod_d = mac_sum;
        if (k_q == '0) begin
          state_d = aalr_pkg::ST_EMIT;
        end else begin
          k_d = k_q - 1'b1;
        end
      end

      aalr_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_d      = 1'b1;
          oval_d    = direct_q ? sample_q : scaled;
          oidx_d    = aalr_pkg::INDEX_W'(cnt_q);
          orun_d    = !more;
          oline_d   = (cnt_inc == ol);
          acc_d     = '0;
          cur_d     = cur_max;
          cnt_d     = cnt_inc;
          bin_end_d = be_next;
          n_d       = n_q + 1'b1;
          state_d   = aalr_pkg::ST_LOOP;
        end
      end

      default: state_d = aalr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= aalr_pkg::ST_IDLE;
      started_q <= 1'b0;
      pos_q     <= '0;
      bin_end_q <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
      direct_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      pos_q     <= pos_d;
      bin_end_q <= bin_end_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      k_q       <= k_d;
      direct_q  <= direct_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    cur_q     <= cur_d;
    seg_end_q <= seg_end_d;
    thr_q     <= thr_d;
    prod_q    <= prod_d;
    oval_q    <= oval_d;
    oidx_q    <= oidx_d;
    orun_q    <= orun_d;
    oline_q   <= oline_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.value        = oval_q;
  assign out_o.out_index    = oidx_q;
  assign out_o.last_of_run  = orun_q;
  assign out_o.last_of_line = oline_q;

`ifndef NO_ASSERTIONS
  // emit waits while the output register is still occupied
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aalr_pkg::ST_EMIT && ov_q && !out_o.ready) |=> state_q == aalr_pkg::ST_EMIT)
    else $error("emit step left with output register full");

  // a closed bin always leaves an empty accumulator
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aalr_pkg::ST_EMIT && out_free) |=> acc_q == '0)
    else $error("accumulator not cleared after emit");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_UPSAMPLE)
    else $error("more results in one run than allowed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_LENGTH)
    else $error("output count beyond line length");
`endif

endmodule

>>> design/aalr_cfg.sv
// APB register file holding the line lengths and the reciprocal.
module aalr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aalr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [aalr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [aalr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output aalr_pkg::cfg_t                   cfg_o
);

  aalr_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        aalr_pkg::REG_IN_LENGTH:
          cfg_d.in_length = pwdata[aalr_pkg::LEN_REG_W-1:0];
        aalr_pkg::REG_OUT_LENGTH:
          cfg_d.out_length = pwdata[aalr_pkg::LEN_REG_W-1:0];
        aalr_pkg::REG_INV_IN_LENGTH:
          cfg_d.inv_in_length = pwdata[aalr_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aalr_pkg::REG_IN_LENGTH:     prdata = aalr_pkg::APB_DATA_W'(cfg_q.in_length);
      aalr_pkg::REG_OUT_LENGTH:    prdata = aalr_pkg::APB_DATA_W'(cfg_q.out_length);
      aalr_pkg::REG_INV_IN_LENGTH: prdata = aalr_pkg::APB_DATA_W'(cfg_q.inv_in_length);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_length     <= aalr_pkg::LEN_RESET;
      cfg_q.out_length    <= aalr_pkg::LEN_RESET;
      cfg_q.inv_in_length <= aalr_pkg::INV_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/aalr_mac.sv
// Shared multiply-accumulate unit: sum = (base, optionally shifted up by A_W) + a * b.
module aalr_mac #(
  parameter int A_W = 16,
  parameter int B_W = 25,
  parameter int P_W = 57
) (
  input  logic [A_W-1:0] a_i,
  input  logic [B_W-1:0] b_i,
  input  logic [P_W-1:0] base_i,
  input  logic           shift_i,
  output logic [P_W-1:0] sum_o
);

  logic [A_W+B_W-1:0] prod;
  logic [P_W-1:0]     base_sel;

  assign prod     = a_i * b_i;
  assign base_sel = shift_i ? (base_i << A_W) : base_i;
  assign sum_o    = base_sel + P_W'(prod);

endmodule
